// ===== hw/rtl/imu_tilt_smoothing_yaw_integrator_core_assert.svh =====
// Assertion macros for the IMU tilt / yaw core.
// Included by the top level; needs clk and rst_n in scope.
`ifndef IMU_TILT_SMOOTHING_YAW_INTEGRATOR_CORE_ASSERT_SVH
`define IMU_TILT_SMOOTHING_YAW_INTEGRATOR_CORE_ASSERT_SVH

// Implication checked every clock edge outside reset.
`define ITS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ITS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/its_pkg.sv =====
// Package for the IMU tilt / yaw core: widths, codes, types, tables.
// No dependencies.
package its_pkg;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = 4;
  localparam int signed AngLimit = 46080;
  localparam int signed RightAngle = 23040;

  typedef enum logic [1:0] {
    REG_ROLL_OFS  = 2'd0,
    REG_PITCH_OFS = 2'd1,
    REG_RATE_OFS  = 2'd2,
    REG_WEIGHT    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_ROLL_INIT, ST_ROLL_ITER, ST_ROLL_DONE,
    ST_PITCH_INIT, ST_PITCH_ITER, ST_PITCH_DONE,
    ST_SMOOTH_A, ST_SMOOTH_B, ST_YAW_A, ST_YAW_B, ST_YAW_C, ST_YAW_D, ST_OUT
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic load;
    logic sqrt_init;
    logic sqrt_step;
    logic cordic_init;
    logic cordic_sel;   // 0 roll, 1 pitch
    logic cordic_step;
    logic angle_roll;
    logic angle_pitch;
    logic smooth_a;
    logic smooth_b;
    logic yaw_a;
    logic yaw_b;
    logic yaw_c;
    logic yaw_d;
    logic [StepW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } stat_t;

  function automatic logic signed [23:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [23:0] v;
    case (i)
      4'd0: v = 24'sd2949120;  4'd1: v = 24'sd1740967;
      4'd2: v = 24'sd919879;   4'd3: v = 24'sd466945;
      4'd4: v = 24'sd234379;   4'd5: v = 24'sd117304;
      4'd6: v = 24'sd58666;    4'd7: v = 24'sd29335;
      4'd8: v = 24'sd14668;    4'd9: v = 24'sd7334;
      4'd10: v = 24'sd3667;    4'd11: v = 24'sd1833;
      4'd12: v = 24'sd917;     4'd13: v = 24'sd458;
      4'd14: v = 24'sd229;     4'd15: v = 24'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ===== hw/rtl/its_if.sv =====
// Valid/ready channel interfaces for the core.
// Depends on nothing.
interface its_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_z;
  logic [31:0] time_ms;
  modport source (output valid, accel_x, accel_y, accel_z, rate_z, time_ms, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_z, time_ms, output ready);
endinterface

interface its_out_if;
  logic valid;
  logic ready;
  logic signed [16:0] roll;
  logic signed [16:0] pitch;
  logic signed [31:0] heading;
  modport source (output valid, roll, pitch, heading, input ready);
  modport sink (input valid, roll, pitch, heading, output ready);
endinterface

interface its_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/its_ctrl.sv =====
// Sequencer for the core: steps sqrt, CORDIC, smoothing and yaw phases.
// Depends on its_pkg.
module its_ctrl
  import its_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQRT;
      ST_SQRT: if (stat.sqrt_done) state_nxt = ST_ROLL_INIT;
      ST_ROLL_INIT: begin
        state_nxt = ST_ROLL_ITER;
        step_nxt = '0;
      end
      ST_ROLL_ITER: begin
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(CordicSteps - 1)) state_nxt = ST_ROLL_DONE;
      end
      ST_ROLL_DONE: state_nxt = ST_PITCH_INIT;
      ST_PITCH_INIT: begin
        state_nxt = ST_PITCH_ITER;
        step_nxt = '0;
      end
      ST_PITCH_ITER: begin
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(CordicSteps - 1)) state_nxt = ST_PITCH_DONE;
      end
      ST_PITCH_DONE: state_nxt = ST_SMOOTH_A;
      ST_SMOOTH_A: state_nxt = ST_SMOOTH_B;
      ST_SMOOTH_B: state_nxt = ST_YAW_A;
      ST_YAW_A: state_nxt = ST_YAW_B;
      ST_YAW_B: state_nxt = ST_YAW_C;
      ST_YAW_C: state_nxt = ST_YAW_D;
      ST_YAW_D: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.step = step_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.sqrt_init = in_valid;
      end
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_ROLL_INIT: cmd.cordic_init = 1'b1;
      ST_ROLL_ITER: cmd.cordic_step = 1'b1;
      ST_ROLL_DONE: cmd.angle_roll = 1'b1;
      ST_PITCH_INIT: begin
        cmd.cordic_init = 1'b1;
        cmd.cordic_sel = 1'b1;
      end
      ST_PITCH_ITER: begin
        cmd.cordic_step = 1'b1;
        cmd.cordic_sel = 1'b1;
      end
      ST_PITCH_DONE: cmd.angle_pitch = 1'b1;
      ST_SMOOTH_A: cmd.smooth_a = 1'b1;
      ST_SMOOTH_B: cmd.smooth_b = 1'b1;
      ST_YAW_A: cmd.yaw_a = 1'b1;
      ST_YAW_B: cmd.yaw_b = 1'b1;
      ST_YAW_C: cmd.yaw_c = 1'b1;
      ST_YAW_D: cmd.yaw_d = 1'b1;
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end
endmodule

// ===== hw/rtl/its_dp.sv =====
// Datapath: two bit-serial square roots, shared CORDIC, smoothing, yaw sum.
// Depends on its_pkg.
module its_dp
  import its_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_z,
  input  logic [31:0]        time_ms,
  input  logic               cfg_we,
  input  reg_idx_t           cfg_idx,
  input  logic [31:0]        cfg_data,
  output logic signed [16:0] roll,
  output logic signed [16:0] pitch,
  output logic signed [31:0] heading
);
  // Config registers
  logic signed [16:0] roll_ofs_r, pitch_ofs_r;
  logic signed [15:0] rate_ofs_r;
  logic [15:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_ofs_r <= '0;
      pitch_ofs_r <= '0;
      rate_ofs_r <= '0;
      weight_r <= 16'd2621;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROLL_OFS: roll_ofs_r <= cfg_data[16:0];
        REG_PITCH_OFS: pitch_ofs_r <= cfg_data[16:0];
        REG_RATE_OFS: rate_ofs_r <= cfg_data[15:0];
        REG_WEIGHT: weight_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sample latch
  logic signed [15:0] ax_r, ay_r, rz_r;
  logic [31:0] now_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= accel_x;
      ay_r <= accel_y;
      rz_r <= rate_z;
      now_r <= time_ms;
    end
  end

  // Integer square roots, one result bit per cycle (sum of squares <= 2^31)
  logic [31:0] rem_r_r, rem_p_r, res_r_r, res_p_r, bit_r;
  logic [31:0] sq_x, sq_y, sq_z;
  assign sq_x = 32'(accel_x * accel_x);
  assign sq_y = 32'(accel_y * accel_y);
  assign sq_z = 32'(accel_z * accel_z);
  assign stat.sqrt_done = (bit_r[31:2] == '0);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_r_r <= sq_x + sq_z;
      rem_p_r <= sq_y + sq_z;
      res_r_r <= '0;
      res_p_r <= '0;
      bit_r <= 32'h4000_0000;
    end else if (cmd.sqrt_step) begin
      if (rem_r_r >= res_r_r + bit_r) begin
        rem_r_r <= rem_r_r - (res_r_r + bit_r);
        res_r_r <= (res_r_r >> 1) + bit_r;
      end else begin
        res_r_r <= res_r_r >> 1;
      end
      if (rem_p_r >= res_p_r + bit_r) begin
        rem_p_r <= rem_p_r - (res_p_r + bit_r);
        res_p_r <= (res_p_r >> 1) + bit_r;
      end else begin
        res_p_r <= res_p_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Shared CORDIC vectoring unit
  logic signed [27:0] cx_r, cy_r;
  logic signed [27:0] cxs, cys;
  logic signed [25:0] cz_r;
  logic signed [16:0] num;
  logic [16:0] den;
  logic zero_r;
  logic signed [16:0] num_r;
  assign num = cmd.cordic_sel ? -17'(ax_r) : 17'(ay_r);
  assign den = cmd.cordic_sel ? res_p_r[16:0] : res_r_r[16:0];
  assign cxs = cx_r >>> cmd.step;
  assign cys = cy_r >>> cmd.step;

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx_r <= {3'b000, den, 8'h00};
      cy_r <= {{3{num[16]}}, num, 8'h00};
      cz_r <= '0;
      zero_r <= (den == '0);
      num_r <= num;
    end else if (cmd.cordic_step) begin
      if (!cy_r[27]) begin
        cx_r <= cx_r + cys;
        cy_r <= cy_r - cxs;
        cz_r <= cz_r + 26'(atan_q16(cmd.step));
      end else begin
        cx_r <= cx_r - cys;
        cy_r <= cy_r + cxs;
        cz_r <= cz_r - 26'(atan_q16(cmd.step));
      end
    end
  end

  // Angle rounding, clamp and offset
  logic signed [25:0] zr;
  logic signed [17:0] base, corr;
  logic signed [16:0] ang;
  always_comb begin
    zr = (cz_r + 26'sd128) >>> 8;
    if (zero_r) begin
      base = (num_r > 0) ? 18'sd23040 : ((num_r < 0) ? -18'sd23040 : 18'sd0);
    end else if (zr > 26'(RightAngle)) begin
      base = 18'(RightAngle);
    end else if (zr < -26'(RightAngle)) begin
      base = -18'(RightAngle);
    end else begin
      base = zr[17:0];
    end
    corr = cmd.cordic_sel ? base + 18'(pitch_ofs_r) : base - 18'(roll_ofs_r);
    if (cmd.angle_pitch) corr = base + 18'(pitch_ofs_r);
    if (corr > 18'(AngLimit)) ang = 17'(AngLimit);
    else if (corr < -18'(AngLimit)) ang = -17'(AngLimit);
    else ang = corr[16:0];
  end

  logic signed [16:0] ar_r, ap_r;
  always_ff @(posedge clk) begin
    if (cmd.angle_roll) ar_r <= ang;
    if (cmd.angle_pitch) ap_r <= ang;
  end

  // Smoothing: one channel per cycle, multiplies combinational
  logic signed [16:0] roll_f_r, pitch_f_r;
  logic signed [16:0] s_old, s_new;
  logic signed [17:0] wc, wn;
  logic signed [35:0] pa, pb;
  logic signed [36:0] acc;
  logic signed [20:0] sh;
  logic signed [16:0] s_res;
  assign s_old = cmd.smooth_b ? pitch_f_r : roll_f_r;
  assign s_new = cmd.smooth_b ? ap_r : ar_r;
  assign wn = 18'($unsigned(weight_r));
  assign wc = 18'sd65536 - wn;
  assign pa = s_old * wc;
  assign pb = s_new * wn;
  assign acc = 37'(pa) + 37'(pb) + 37'sd32768;
  assign sh = 21'(acc >>> 16);
  assign s_res = (sh > 21'(AngLimit)) ? 17'(AngLimit) :
                 ((sh < -21'(AngLimit)) ? -17'(AngLimit) : sh[16:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_f_r <= '0;
      pitch_f_r <= '0;
    end else begin
      if (cmd.smooth_a) roll_f_r <= s_res;
      if (cmd.smooth_b) pitch_f_r <= s_res;
    end
  end

  // Yaw: product, divide by 1000 via reciprocal, saturating add
  logic [31:0] last_r;
  logic signed [31:0] yaw_r;
  logic signed [16:0] rate;
  logic [31:0] dt;
  logic signed [48:0] prod;
  logic [48:0] mag_r;      // |rate*dt| <= 2^48
  logic neg_r;
  logic [45:0] xdiv;
  logic [24:0] xh;
  logic [20:0] xl;
  logic [29:0] y_r;
  logic [39:0] qh_r;
  logic [60:0] ymul;
  logic [48:0] q_r;
  logic signed [50:0] sum;
  assign rate = 17'(rz_r) + 17'(rate_ofs_r);
  assign dt = now_r - last_r;
  assign prod = 49'(rate * $signed({1'b0, dt}));
  // (m+500)/1000 = x/125 with x = (m+500)>>3. Split x = xh*2^21 + xl;
  // since 2^21 = 125*16777 + 27, x/125 = 16777*xh + (27*xh + xl)/125.
  assign xdiv = 46'((mag_r + 49'd500) >> 3);
  assign xh = xdiv[45:21];
  assign xl = xdiv[20:0];
  // y < 2^30, so (y * ceil(2^37/125)) >> 37 is the exact quotient by 125
  assign ymul = 61'(y_r) * 61'd1099511628;
  assign sum = 51'(yaw_r) + (neg_r ? -51'($signed({2'b00, q_r})) : 51'($signed({2'b00, q_r})));

  always_ff @(posedge clk) begin
    if (cmd.yaw_a) begin
      neg_r <= prod[48];
      mag_r <= prod[48] ? 49'(-prod) : 49'(prod);
    end
    if (cmd.yaw_b) begin
      y_r <= 30'(30'd27 * 30'(xh) + 30'(xl));
      qh_r <= 40'd16777 * 40'(xh);
    end
    if (cmd.yaw_c) q_r <= 49'(qh_r) + 49'(ymul >> 37);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      yaw_r <= '0;
    end else if (cmd.yaw_d) begin
      last_r <= now_r;
      if (sum > 51'sh7FFF_FFFF) yaw_r <= 32'sh7FFF_FFFF;
      else if (sum < -51'sh8000_0000) yaw_r <= 32'sh8000_0000;
      else yaw_r <= sum[31:0];
    end
  end

  assign roll = roll_f_r;
  assign pitch = pitch_f_r;
  assign heading = yaw_r;
endmodule

// ===== hw/rtl/imu_tilt_smoothing_yaw_integrator_core.sv =====
// Top level of the IMU tilt smoothing / yaw integrator core.
// Depends on its_pkg, its_if, its_ctrl, its_dp and the assertion header.
//
// channel | role  | payload
// in_     | sink  | accel_x/y/z, rate_z, time_ms
// out_    | source| roll, pitch, heading
// cfg_    | sink  | index, data (always ready)
//
// Each sample runs, accept to accept, through the accept cycle, 16 square-root
// steps, two CORDIC passes (init, 16 steps, angle) on the shared unit, the
// smoothing states SMOOTH_A/B, the yaw states YAW_A to YAW_D and the output state.
// Result is held in output registers until taken; an output stall delays the
// next sample, which is accepted after the result transaction.
// Reset is synchronous, active low.
`include "imu_tilt_smoothing_yaw_integrator_core_assert.svh"
module imu_tilt_smoothing_yaw_integrator_core
  import its_pkg::*;
(
  input logic clk,
  input logic rst_n,
  its_in_if.sink    in_ch,
  its_out_if.source out_ch,
  its_cfg_if.sink   cfg_ch
);
  cmd_t cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  its_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  its_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .accel_x(in_ch.accel_x), .accel_y(in_ch.accel_y), .accel_z(in_ch.accel_z),
    .rate_z(in_ch.rate_z), .time_ms(in_ch.time_ms),
    .cfg_we(cfg_ch.valid), .cfg_idx(reg_idx_t'(cfg_ch.index)), .cfg_data(cfg_ch.data),
    .roll(out_ch.roll), .pitch(out_ch.pitch), .heading(out_ch.heading)
  );

  // Never accept and present a result in the same cycle
  `ITS_ASSERT_IMP(a_no_overlap, in_ch.ready, !out_ch.valid)
  // Result waits until taken
  `ITS_ASSERT_NXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
  // Accepted sample starts work
  `ITS_ASSERT_NXT(a_start, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule
